>>> hdl/rbcb_pkg.sv
// shared constants, types and index helpers for the ring buffer with contiguous burst
package rbcb_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SAMPLE_W = 16;
    localparam int RUN_W    = 6;
    localparam int LEN_W    = (IDX_W + 1 > RUN_W) ? IDX_W + 1 : RUN_W;

    localparam logic [RUN_W-1:0] RUN_CAP = {RUN_W{1'b1}};

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [RUN_W-1:0]    run_t;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_TAKE   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // request bundle from the sequencer to the sample memory
    typedef struct packed {
        logic    wr_en;
        idx_t    wr_addr;
        sample_t wr_data;
        logic    rd_en;
        idx_t    rd_addr;
    } mem_req_t;

    function automatic idx_t wrap_inc(input idx_t i);
        idx_t res;
        if (i == idx_t'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = i + idx_t'(1);
        end
        return res;
    endfunction

    function automatic logic ring_full(input idx_t w, input idx_t r);
        return (wrap_inc(w) == r);
    endfunction

    function automatic logic ring_empty(input idx_t w, input idx_t r);
        return (w == r);
    endfunction

    // contiguous readable count, saturated to the run field
    function automatic run_t run_len(input idx_t w, input idx_t r);
        logic [LEN_W-1:0] raw;
        run_t             res;
        if (w == r)
        begin
            raw = '0;
        end
        else if (w < r)
        begin
            raw = LEN_W'(DEPTH) - LEN_W'(r);
        end
        else
        begin
            raw = LEN_W'(w) - LEN_W'(r);
        end
        if (raw > LEN_W'(RUN_CAP))
        begin
            res = RUN_CAP;
        end
        else
        begin
            res = raw[RUN_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/rbcb_mem.sv
// sample store: one write port, one read port with registered read data
module rbcb_mem
(
    input  logic                clk,
    input  rbcb_pkg::mem_req_t  req,
    output rbcb_pkg::sample_t   rd_data
);

    rbcb_pkg::sample_t mem [rbcb_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

>>> hdl/ring_buffer_with_contiguous_burst.sv
// top level: index registers, command sequencer and result registers around the sample store
//
// A ring of 64 sixteen-bit slots holding up to 63 samples. A command beat is
// taken when start is high and busy is low. Push, pop and status-only never
// raise busy, so they can be issued back to back, and give one result
// beat on the cycle after they are taken. A take-run of n samples (n capped
// at 63) gives n result beats, one sample per cycle through the single read
// port of the store, and holds busy high while the samples after the first
// are read. Every result beat is shown for one cycle with strobe high; the
// receiver cannot stall the block, so it must take each beat as it comes.
// Flags and run_length on a beat show the ring after that beat. Empty pops
// and takes, and refused pushes, give a single beat with ok low and data zero.
module ring_buffer_with_contiguous_burst
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] sample,
    output logic        strobe,
    output logic [15:0] data,
    output logic        ok,
    output logic        last,
    output logic        is_full,
    output logic        is_empty,
    output logic [5:0]  run_length
);

    // indices and sequencer state
    rbcb_pkg::idx_t   widx_reg, widx_next;
    rbcb_pkg::idx_t   ridx_reg, ridx_next;
    rbcb_pkg::state_t state_reg, state_next;
    rbcb_pkg::run_t   left_reg, left_next;

    // result beat registers
    logic             strobe_reg, strobe_next;
    logic             ok_reg, ok_next;
    logic             last_reg, last_next;
    logic             full_reg, full_next;
    logic             empty_reg, empty_next;
    rbcb_pkg::run_t   len_reg, len_next;
    logic             rd_sel_reg, rd_sel_next;

    rbcb_pkg::mem_req_t req;
    rbcb_pkg::sample_t  rd_data;
    rbcb_pkg::run_t     cur_len;
    rbcb_pkg::cmd_t     cmd;

    rbcb_mem u_mem
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign cmd     = rbcb_pkg::cmd_t'(command);
    assign cur_len = rbcb_pkg::run_len(widx_reg, ridx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rbcb_pkg::ST_IDLE;
            widx_reg   <= '0;
            ridx_reg   <= '0;
            left_reg   <= '0;
            strobe_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            widx_reg   <= widx_next;
            ridx_reg   <= ridx_next;
            left_reg   <= left_next;
            strobe_reg <= strobe_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    // beat payload, only meaningful while strobe is high
    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        last_reg  <= last_next;
        full_reg  <= full_next;
        empty_reg <= empty_next;
        len_reg   <= len_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        widx_next    = widx_reg;
        ridx_next    = ridx_reg;
        left_next    = left_reg;
        strobe_next  = 1'b0;
        ok_next      = 1'b0;
        last_next    = 1'b1;
        rd_sel_next  = 1'b0;
        req.wr_en    = 1'b0;
        req.wr_addr  = widx_reg;
        req.wr_data  = sample;
        req.rd_en    = 1'b0;
        req.rd_addr  = ridx_reg;

        case (state_reg)
            rbcb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    case (cmd)
                        rbcb_pkg::CMD_PUSH:
                        begin
                            if (!rbcb_pkg::ring_full(widx_reg, ridx_reg))
                            begin
                                req.wr_en = 1'b1;
                                widx_next = rbcb_pkg::wrap_inc(widx_reg);
                                ok_next   = 1'b1;
                            end
                        end
                        rbcb_pkg::CMD_POP:
                        begin
                            if (!rbcb_pkg::ring_empty(widx_reg, ridx_reg))
                            begin
                                req.rd_en   = 1'b1;
                                ridx_next   = rbcb_pkg::wrap_inc(ridx_reg);
                                ok_next     = 1'b1;
                                rd_sel_next = 1'b1;
                            end
                        end
                        rbcb_pkg::CMD_TAKE:
                        begin
                            // first sample of the run goes out straight away
                            if (cur_len != '0)
                            begin
                                req.rd_en   = 1'b1;
                                ridx_next   = rbcb_pkg::wrap_inc(ridx_reg);
                                ok_next     = 1'b1;
                                rd_sel_next = 1'b1;
                                last_next   = (cur_len == rbcb_pkg::run_t'(1));
                                left_next   = cur_len - rbcb_pkg::run_t'(1);
                                if (cur_len != rbcb_pkg::run_t'(1))
                                begin
                                    state_next = rbcb_pkg::ST_RUN;
                                end
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b1;
                        end
                    endcase
                end
            end
            rbcb_pkg::ST_RUN:
            begin
                // one sample of the burst per cycle
                strobe_next = 1'b1;
                req.rd_en   = 1'b1;
                ridx_next   = rbcb_pkg::wrap_inc(ridx_reg);
                ok_next     = 1'b1;
                rd_sel_next = 1'b1;
                last_next   = (left_reg == rbcb_pkg::run_t'(1));
                left_next   = left_reg - rbcb_pkg::run_t'(1);
                if (left_reg == rbcb_pkg::run_t'(1))
                begin
                    state_next = rbcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbcb_pkg::ST_IDLE;
            end
        endcase

        // flags describe the ring after this beat
        full_next  = rbcb_pkg::ring_full(widx_next, ridx_next);
        empty_next = rbcb_pkg::ring_empty(widx_next, ridx_next);
        len_next   = rbcb_pkg::run_len(widx_next, ridx_next);
    end

    assign busy       = (state_reg == rbcb_pkg::ST_RUN);
    assign strobe     = strobe_reg;
    assign data       = rd_sel_reg ? rd_data : '0;
    assign ok         = ok_reg;
    assign last       = last_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;
    assign run_length = len_reg;

endmodule

>>> hdl/rbcb_checker.sv
// port-level checker for the ring buffer with contiguous burst, bound to the top level
module rbcb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       ok,
    input logic       last,
    input logic       is_full,
    input logic       is_empty,
    input logic [5:0] run_length
);

    // every command taken gives a beat on the next cycle
    a_cmd_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> strobe)
        else $error("no result beat after a taken command");

    // a burst does not break before its last beat
    a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && ok))
        else $error("burst broke off before its last beat");

    // commands are held off while a burst is still going
    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("busy low in the middle of a burst");

    a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (!(is_full && is_empty) && (is_empty == (run_length == 6'd0))))
        else $error("full, empty and run length disagree");

endmodule

bind ring_buffer_with_contiguous_burst rbcb_checker u_rbcb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .ok         (ok),
    .last       (last),
    .is_full    (is_full),
    .is_empty   (is_empty),
    .run_length (run_length)
);

>>> verif/rbcb_checker.sv
// checker for the ring buffer: tracks its own copy of the ring and compares every result beat
module rbcb_tb_checker
    import rbcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] sample,
    input  logic        strobe,
    input  logic [15:0] data,
    input  logic        ok,
    input  logic        last,
    input  logic        is_full,
    input  logic        is_empty,
    input  logic [5:0]  run_length,
    output int          fail_count,
    output int          outstanding
);

    typedef struct {
        sample_t value;
        logic    good;
        logic    tail;
        logic    full;
        logic    empty;
        run_t    span;
    } ring_beat_t;

    sample_t    ring_store [DEPTH];
    idx_t       wr_ptr;
    idx_t       rd_ptr;
    ring_beat_t expected_beats [$];

    function automatic idx_t step_ptr(input idx_t p);
        return idx_t'((int'(p) + 1) % DEPTH);
    endfunction

    // readable stretch from the read pointer, stopping at the end of the store
    function automatic run_t span_len(input idx_t w, input idx_t r);
        int n;
        if (w == r)
        begin
            n = 0;
        end
        else if (w < r)
        begin
            n = DEPTH - int'(r);
        end
        else
        begin
            n = int'(w) - int'(r);
        end
        if (n > 63)
        begin
            n = 63;
        end
        return run_t'(n);
    endfunction

    // queue one beat, flags taken from the ring as it stands now
    task automatic queue_beat(input sample_t v, input logic g, input logic t);
        ring_beat_t b;
        b.value = v;
        b.good  = g;
        b.tail  = t;
        b.full  = (step_ptr(wr_ptr) == rd_ptr);
        b.empty = (wr_ptr == rd_ptr);
        b.span  = span_len(wr_ptr, rd_ptr);
        expected_beats.push_back(b);
    endtask

    task automatic predict_command(input cmd_t c, input sample_t s);
        int n;
        case (c)
            CMD_PUSH:
            begin
                if (step_ptr(wr_ptr) == rd_ptr)
                begin
                    queue_beat('0, 1'b0, 1'b1);
                end
                else
                begin
                    ring_store[wr_ptr] = s;
                    wr_ptr = step_ptr(wr_ptr);
                    queue_beat('0, 1'b1, 1'b1);
                end
            end
            CMD_POP:
            begin
                if (wr_ptr == rd_ptr)
                begin
                    queue_beat('0, 1'b0, 1'b1);
                end
                else
                begin
                    s = ring_store[rd_ptr];
                    rd_ptr = step_ptr(rd_ptr);
                    queue_beat(s, 1'b1, 1'b1);
                end
            end
            CMD_TAKE:
            begin
                n = int'(span_len(wr_ptr, rd_ptr));
                if (n == 0)
                begin
                    queue_beat('0, 1'b0, 1'b1);
                end
                for (int i = 0; i < n; i++)
                begin
                    s = ring_store[rd_ptr];
                    rd_ptr = step_ptr(rd_ptr);
                    queue_beat(s, 1'b1, i == n - 1);
                end
            end
            default:
            begin
                queue_beat('0, 1'b1, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ring_beat_t b;
        if (!rst_n)
        begin
            wr_ptr = '0;
            rd_ptr = '0;
            expected_beats.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat expected none got data %h", $time, data);
                    fail_count++;
                end
                else
                begin
                    b = expected_beats.pop_front();
                    check_field("data", b.value, data);
                    check_field("ok", 16'(b.good), 16'(ok));
                    check_field("last", 16'(b.tail), 16'(last));
                    check_field("is_full", 16'(b.full), 16'(is_full));
                    check_field("is_empty", 16'(b.empty), 16'(is_empty));
                    check_field("run_length", 16'(b.span), 16'(run_length));
                end
            end
            if (start && !busy)
            begin
                predict_command(cmd_t'(command), sample);
            end
            outstanding = expected_beats.size();
        end
    end

endmodule

>>> verif/tb_ring_buffer_with_contiguous_burst.sv
// testbench top: clock, reset, command stimulus, watchdog and verdict for the ring buffer
module tb_ring_buffer_with_contiguous_burst;
    import rbcb_pkg::*;

    // longest stretch with no beat in either direction before the run is abandoned
    localparam int QUIET_LIMIT = 400;
    localparam int ITEM_TARGET = 430;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [15:0] sample;
    logic        strobe;
    logic [15:0] data;
    logic        ok;
    logic        last;
    logic        is_full;
    logic        is_empty;
    logic [5:0]  run_length;

    int fail_count;
    int outstanding;
    int issued;
    bit gaps_on;

    ring_buffer_with_contiguous_burst dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .sample     (sample),
        .strobe     (strobe),
        .data       (data),
        .ok         (ok),
        .last       (last),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .run_length (run_length)
    );

    rbcb_tb_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .sample      (sample),
        .strobe      (strobe),
        .data        (data),
        .ok          (ok),
        .last        (last),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .run_length  (run_length),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = ~clk;
    end

    // sample values lean on the all-zero and all-one patterns now and then
    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'h0000;
        end
        else if (r == 1)
        begin
            return 16'hFFFF;
        end
        return sample_t'($urandom_range(0, 65535));
    endfunction

    // idle cycles after a beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // called at a falling edge; returns at a falling edge once the beat is taken
    task automatic issue(input cmd_t c, input sample_t s);
        int gap;
        start   <= 1'b1;
        command <= c;
        sample  <= s;
        // busy is registered, so its value just before the edge decides acceptance
        do
            @(posedge clk);
        while (busy);
        issued++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            // idle inputs carry junk, which the block must ignore
            start   <= 1'b0;
            command <= 2'($urandom_range(0, 3));
            sample  <= 16'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // random command mix, weighted towards pushes so the ring does not stay empty
    task automatic issue_mixed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            issue(CMD_PUSH, pick_sample());
        end
        else if (r < 70)
        begin
            issue(CMD_POP, pick_sample());
        end
        else if (r < 85)
        begin
            issue(CMD_TAKE, pick_sample());
        end
        else
        begin
            issue(CMD_STATUS, pick_sample());
        end
    endtask

    // watchdog: ends the run when neither side moves a beat for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("ring_buffer_with_contiguous_burst test failed");
        $finish;
    end

    initial
    begin
        int k;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = 2'd0;
        sample  = 16'd0;
        issued  = 0;
        gaps_on = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty-ring commands first, then the sample extremes
        issue(CMD_STATUS, 16'h0000);
        issue(CMD_POP, 16'hFFFF);
        issue(CMD_TAKE, 16'hFFFF);
        issue(CMD_PUSH, 16'h0000);
        issue(CMD_PUSH, 16'hFFFF);
        issue(CMD_PUSH, 16'h5A5A);
        issue(CMD_PUSH, 16'hA5A5);
        issue(CMD_STATUS, 16'h1234);
        issue(CMD_POP, 16'h0000);
        // take-run over three samples, then one on the emptied ring
        issue(CMD_TAKE, 16'h0000);
        issue(CMD_TAKE, 16'h0000);
        issue(CMD_PUSH, 16'h8001);
        issue(CMD_PUSH, 16'h7FFE);
        issue(CMD_POP, 16'h0000);
        issue(CMD_POP, 16'h0000);
        issue(CMD_POP, 16'h0000);
        issue(CMD_STATUS, 16'hFFFF);

        // random phases: fills that run into full, drains, and mixed traffic,
        // so the pointers wrap and take-runs stop at the end of the store
        while (issued < ITEM_TARGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    // long fills can overrun the ring and exercise refused pushes
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 20);
                    repeat (k) issue(CMD_PUSH, pick_sample());
                end
                1:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        if ($urandom_range(0, 2) != 0)
                        begin
                            issue(CMD_TAKE, pick_sample());
                        end
                        else
                        begin
                            issue(CMD_POP, pick_sample());
                        end
                    end
                end
                default:
                begin
                    repeat ($urandom_range(5, 25)) issue_mixed();
                end
            endcase
        end

        start <= 1'b0;
        // wait for the last burst to drain, then a short settling margin
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("ring_buffer_with_contiguous_burst test passed");
        end
        else
        begin
            $display("ring_buffer_with_contiguous_burst test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rbcb_pkg.sv
hdl/rbcb_mem.sv
hdl/ring_buffer_with_contiguous_burst.sv
hdl/rbcb_checker.sv
verif/rbcb_checker.sv
verif/tb_ring_buffer_with_contiguous_burst.sv
